// File: src/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WIN_W    = 7;
  localparam int unsigned OUT_W    = 33;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

  // What one cell shows its neighbours: its value and its two decision flags.
  typedef struct packed {
    logic                       valid;
    logic                       gt;     // value lies above the new sample
    logic                       rm;     // at or right of the evicted entry
    logic signed [SAMPLE_W-1:0] value;
  } swm_link_t;

  localparam swm_link_t LINK_LEFT_EDGE  = '{valid: 1'b1, gt: 1'b0, rm: 1'b0, value: '0};
  localparam swm_link_t LINK_RIGHT_EDGE = '{valid: 1'b0, gt: 1'b1, rm: 1'b1, value: '0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SELECT,
    ST_SUM
  } swm_state_e;

endpackage : swm_pkg

`default_nettype wire

// File: src/swm_cell.sv
// One cell of the sorted chain: holds one window value and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        clear_i,
  input  wire logic                                        shift_i,
  input  wire logic                                        evict_en_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0]         sample_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0]         evict_i,
  input  wire swm_pkg::swm_link_t                          left_i,
  input  wire swm_pkg::swm_link_t                          right_i,
  output swm_pkg::swm_link_t                               link_o
);
  import swm_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  swm_link_t                  own;
  swm_link_t                  b_self;
  swm_link_t                  b_left;

  always_comb begin
    own.valid = valid_q;
    own.value = value_q;
    own.gt    = !valid_q || (value_q > sample_i);
    own.rm    = evict_en_i && (!valid_q || (value_q >= evict_i));
  end

  assign link_o = own;

  // First close the gap left by the evicted entry, then open one for the sample.
  always_comb begin
    b_self  = own.rm ? right_i : own;
    b_left  = left_i.rm ? own : left_i;
    valid_d = b_self.valid;
    value_d = b_self.value;
    if (b_self.gt) begin
      if (!b_left.gt) begin
        valid_d = 1'b1;
        value_d = sample_i;
      end else begin
        valid_d = b_left.valid;
        value_d = b_left.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= value_d;
    end
  end

endmodule : swm_cell

`default_nettype wire

// File: src/swm_ring.sv
// Arrival-order ring memory: one port, read of the old word while writing the new.
`timescale 1ns / 1ps
`default_nettype none

module swm_ring #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0]        wdata_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0]             rdata_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule : swm_ring

`default_nettype wire

// File: src/sliding_window_median.sv
// Sliding window median filter: the window kept in a ring and in a sorted cell chain.
// A word that completes the window has its result in the output register after the ring
// access, chain shift, median select and sum steps in turn; the sum waits while an untaken
// result holds the output register. The sequencer takes no new word until it is back in idle,
// and while the window fills it skips the select and sum steps. Reset clears the control state
// and cell valid bits and sets the window size to three; ring contents and cell values are
// undefined, there is no clearing pass, and the block takes words straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Window size register write channel
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [swm_pkg::WIN_W-1:0]              window_size_i,
  // Sample input
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0]    sample_i,
  input  wire logic                                   restart_i,
  // Median output
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [swm_pkg::OUT_W-1:0]            median_times_two_o
);
  import swm_pkg::*;

  localparam int unsigned AddrW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_MAX + 1);

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  swm_state_e                 state_q, state_d;
  logic [WIN_W-1:0]           win_q, win_d;
  logic [CntW-1:0]            fill_q, fill_d;
  logic [AddrW-1:0]           oldest_q, oldest_d;
  logic                       evict_en_q, evict_en_d;
  logic                       emit_q, emit_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] lo_q, hi_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]    out_q;

  // ------------------------------------------------------------------
  // Handshakes and sequencer controls
  // ------------------------------------------------------------------
  logic cfg_write;
  logic in_accept;
  logic cell_shift;
  logic sel_load;
  logic sum_room;
  logic out_load;

  assign cfg_write = cfg_valid_i && cfg_ready_o;
  assign in_accept = in_valid_i && !in_stall_o;
  assign sum_room  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_SHIFT;
      ST_SHIFT:  state_d = emit_q ? ST_SELECT : ST_IDLE;
      ST_SELECT: state_d = ST_SUM;
      ST_SUM:    if (sum_room) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready_o = 1'b0;
    in_stall_o  = 1'b1;
    cell_shift  = 1'b0;
    sel_load    = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_stall_o  = 1'b0;
      end
      ST_SHIFT:  cell_shift = 1'b1;
      ST_SELECT: sel_load   = 1'b1;
      ST_SUM:    out_load   = sum_room;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Effective window: zero acts as one, anything past the chain length as the full chain.
  // ------------------------------------------------------------------
  logic [CntW-1:0] win_eff;

  always_comb begin
    if (win_q == '0) begin
      win_eff = CntW'(1);
    end else if (int'(win_q) > int'(WINDOW_MAX)) begin
      win_eff = CntW'(WINDOW_MAX);
    end else begin
      win_eff = CntW'(win_q);
    end
  end

  // ------------------------------------------------------------------
  // Fill and ring bookkeeping, all resolved at the acceptance edge.
  // A restart behaves as if the count and ring pointer were already zero.
  // ------------------------------------------------------------------
  logic [CntW-1:0]  fill_eff;
  logic [AddrW-1:0] oldest_eff;
  logic             win_full;
  logic [AddrW-1:0] ring_addr;

  assign fill_eff   = restart_i ? '0 : fill_q;
  assign oldest_eff = restart_i ? '0 : oldest_q;
  assign win_full   = fill_eff >= win_eff;
  assign ring_addr  = win_full ? oldest_eff : fill_eff[AddrW-1:0];

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    oldest_d   = oldest_q;
    evict_en_d = evict_en_q;
    emit_d     = emit_q;
    if (cfg_write) begin
      win_d    = window_size_i;
      fill_d   = '0;
      oldest_d = '0;
    end else if (in_accept) begin
      evict_en_d = win_full;
      if (win_full) begin
        // Window full: the oldest word leaves, the pointer wraps at the window size.
        fill_d   = win_eff;
        oldest_d = ((CntW'(oldest_eff) + CntW'(1)) == win_eff) ? '0 : oldest_eff + AddrW'(1);
        emit_d   = 1'b1;
      end else begin
        fill_d   = fill_eff + CntW'(1);
        oldest_d = '0;
        emit_d   = (fill_eff + CntW'(1)) == win_eff;
      end
    end
  end

  // ------------------------------------------------------------------
  // Arrival ring: the evicted word is read while the new one is written.
  // ------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] evict_val;

  swm_ring #(
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .addr_i  (ring_addr),
    .wdata_i (sample_i),
    .rdata_o (evict_val)
  );

  // ------------------------------------------------------------------
  // Sorted chain. Equal values sit in arrival order, so the evicted word is always the
  // leftmost copy of its value; each cell decides from its own compares and its two
  // neighbours whether it keeps, takes the new sample or takes a neighbour's value.
  // ------------------------------------------------------------------
  logic      cell_clear;
  swm_link_t cell_link [WINDOW_MAX];

  assign cell_clear = cfg_write || (in_accept && restart_i);

  for (genvar gi = 0; gi < int'(WINDOW_MAX); gi++) begin : g_cell
    swm_link_t left_link;
    swm_link_t right_link;

    if (gi == 0) begin : g_left_edge
      assign left_link = LINK_LEFT_EDGE;
    end else begin : g_left_cell
      assign left_link = cell_link[gi-1];
    end

    if (gi == int'(WINDOW_MAX) - 1) begin : g_right_edge
      assign right_link = LINK_RIGHT_EDGE;
    end else begin : g_right_cell
      assign right_link = cell_link[gi+1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (cell_clear),
      .shift_i    (cell_shift),
      .evict_en_i (evict_en_q),
      .sample_i   (sample_q),
      .evict_i    (evict_val),
      .left_i     (left_link),
      .right_i    (right_link),
      .link_o     (cell_link[gi])
    );
  end

  // ------------------------------------------------------------------
  // Median taps: the middle cell for an odd window, the two middle cells for an even one.
  // ------------------------------------------------------------------
  logic [CntW-1:0]  mid_cnt;
  logic [AddrW-1:0] idx_hi;
  logic [AddrW-1:0] idx_lo;

  assign mid_cnt = win_eff >> 1;
  assign idx_hi  = mid_cnt[AddrW-1:0];
  assign idx_lo  = win_eff[0] ? idx_hi : idx_hi - AddrW'(1);

  // ------------------------------------------------------------------
  // Output register: a finished median waits here while the next word is taken.
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RESET;
      fill_q      <= '0;
      oldest_q    <= '0;
      evict_en_q  <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      evict_en_q  <= evict_en_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (sel_load) begin
      lo_q <= cell_link[idx_lo].value;
      hi_q <= cell_link[idx_hi].value;
    end
    if (out_load) begin
      out_q <= {lo_q[SAMPLE_W-1], lo_q} + {hi_q[SAMPLE_W-1], hi_q};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign median_times_two_o = out_q;

endmodule : sliding_window_median

`default_nettype wire
